// ===== rtl/pam_pkg.sv =====
`timescale 1ns / 1ps

package pam_pkg;

  localparam int unsigned NumChan   = 3;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned RecipFrac = 24;
  localparam int unsigned RecipW    = RecipFrac + 1;

  localparam logic [ChanW-1:0] ChanMax = 8'hff;
  localparam logic [16:0]      Div255Mul = 17'h08081;

  localparam int unsigned IdxR = 2;
  localparam int unsigned IdxG = 1;
  localparam int unsigned IdxB = 0;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_BG_RED   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BG_GREEN = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BG_BLUE  = 2'd2;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [NumChan-1:0][ChanW-1:0] rgb_t;

  typedef enum logic [1:0] {
    MODE_BG    = 2'd0,
    MODE_PASS  = 2'd1,
    MODE_BLEND = 2'd2
  } pam_mode_e;

  typedef struct packed {
    logic      valid;
    pam_mode_e mode;
    chan_t     alpha;
  } pam_ctl_t;

endpackage

// ===== rtl/pam_pix_if.sv =====
`timescale 1ns / 1ps

interface pam_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_argb;
  logic        pad_row;

  modport source (output valid, output pixel_argb, output pad_row, input ready);
  modport sink (input valid, input pixel_argb, input pad_row, output ready);
endinterface

// ===== rtl/pam_rgb_if.sv =====
`timescale 1ns / 1ps

interface pam_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                output ready);
endinterface

// ===== rtl/pam_unpremul.sv =====
`timescale 1ns / 1ps

module pam_unpremul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [31:0]      pixel_argb_i,
  input  logic             pad_row_i,
  output pam_pkg::pam_ctl_t ctl_o,
  output pam_pkg::rgb_t    chan_o,
  output pam_pkg::rgb_t    unp_o
);
  import pam_pkg::*;

  logic [RecipW-1:0] recip_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_recip
    localparam int unsigned Den = (g == 0) ? 1 : g;
    localparam longint unsigned RecipVal =
      (g == 0) ? 0 : (((64'd1 << RecipFrac) + Den - 1) / Den);
    assign recip_tab[g] = RecipVal[RecipW-1:0];
  end

  chan_t             alpha;
  rgb_t              chan;
  pam_ctl_t          ctl_a_d, ctl_a_q, ctl_b_q;
  rgb_t              chan_a_q, chan_b_q;
  logic [15:0]       num_d [NumChan];
  logic [15:0]       num_a_q [NumChan];
  logic [NumChan-1:0] clamp_d, clamp_a_q;
  logic [RecipW-1:0] recip_a_q;
  logic [40:0]       prod [NumChan];
  rgb_t              unp_d, unp_b_q;

  assign alpha = pixel_argb_i[31:24];
  assign chan  = pixel_argb_i[23:0];

  always_comb begin
    ctl_a_d.valid = valid_i;
    ctl_a_d.alpha = alpha;
    if (pad_row_i || alpha == '0) begin
      ctl_a_d.mode = MODE_BG;
    end else if (alpha == ChanMax) begin
      ctl_a_d.mode = MODE_PASS;
    end else begin
      ctl_a_d.mode = MODE_BLEND;
    end
    for (int i = 0; i < NumChan; i++) begin
      num_d[i]   = {chan[i], 8'h00} - {8'h00, chan[i]};
      clamp_d[i] = chan[i] >= alpha;
    end
  end

  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      prod[i]  = {25'd0, num_a_q[i]} * {16'd0, recip_a_q};
      unp_d[i] = clamp_a_q[i] ? ChanMax : prod[i][RecipFrac+7:RecipFrac];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_a_d;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chan_a_q  <= chan;
      num_a_q   <= num_d;
      clamp_a_q <= clamp_d;
      recip_a_q <= recip_tab[alpha];
      chan_b_q  <= chan_a_q;
      unp_b_q   <= unp_d;
    end
  end

  assign ctl_o  = ctl_b_q;
  assign chan_o = chan_b_q;
  assign unp_o  = unp_b_q;

endmodule

// ===== rtl/pam_blend.sv =====
`timescale 1ns / 1ps

module pam_blend (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  pam_pkg::pam_ctl_t ctl_i,
  input  pam_pkg::rgb_t     chan_i,
  input  pam_pkg::rgb_t     unp_i,
  input  pam_pkg::rgb_t     bg_i,
  output logic              valid_o,
  output pam_pkg::rgb_t     rgb_o
);
  import pam_pkg::*;

  pam_ctl_t    ctl_c_q, ctl_d_q;
  rgb_t        chan_c_q;
  logic [15:0] sum_d [NumChan];
  logic [15:0] sum_c_q [NumChan];
  logic [31:0] quot_prod [NumChan];
  rgb_t        rgb_d, rgb_d_q;
  chan_t       inv_alpha;

  assign inv_alpha = ChanMax - ctl_i.alpha;

  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      sum_d[i] = ({8'h00, unp_i[i]} * {8'h00, ctl_i.alpha})
               + ({8'h00, bg_i[i]} * {8'h00, inv_alpha});
    end
  end

  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      quot_prod[i] = {16'h0000, sum_c_q[i]} * {15'd0, Div255Mul};
      case (ctl_c_q.mode)
        MODE_PASS:  rgb_d[i] = chan_c_q[i];
        MODE_BLEND: rgb_d[i] = quot_prod[i][30:23];
        default:    rgb_d[i] = bg_i[i];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_c_q <= '0;
      ctl_d_q <= '0;
    end else if (en_i) begin
      ctl_c_q <= ctl_i;
      ctl_d_q <= ctl_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chan_c_q <= chan_i;
      sum_c_q  <= sum_d;
      rgb_d_q  <= rgb_d;
    end
  end

  assign valid_o = ctl_d_q.valid;
  assign rgb_o   = rgb_d_q;

endmodule

// ===== rtl/premultiplied_alpha_composite.sv =====
`timescale 1ns / 1ps
// Composites premultiplied a8r8g8b8 pixels onto a programmable background
// color and emits RGB888. The block takes one pixel per clock while the output
// is not stalled. From request to result it runs a reciprocal table lookup,
// a 16x25 reciprocal multiply for un-premultiplying, the blend multiplies,
// and a constant multiply for the divide by 255, each behind its own register.
// The whole pipeline advances together and holds while the output request
// is stalled. Write the background registers only while no pixel is in flight.

module premultiplied_alpha_composite (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pam_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [7:0]                    cfg_data_i,
  pam_pix_if.sink                       pix_i,
  pam_rgb_if.source                     rgb_o
);
  import pam_pkg::*;

  rgb_t     bg_q;
  logic     en;
  pam_ctl_t ctl_b;
  rgb_t     chan_b, unp_b, rgb_res;
  logic     res_valid;

  assign en          = !res_valid || rgb_o.ready;
  assign pix_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BG_RED:   bg_q[IdxR] <= cfg_data_i;
        REG_BG_GREEN: bg_q[IdxG] <= cfg_data_i;
        REG_BG_BLUE:  bg_q[IdxB] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pam_unpremul u_unpremul (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (pix_i.valid),
    .pixel_argb_i (pix_i.pixel_argb),
    .pad_row_i    (pix_i.pad_row),
    .ctl_o        (ctl_b),
    .chan_o       (chan_b),
    .unp_o        (unp_b)
  );

  pam_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (ctl_b),
    .chan_i  (chan_b),
    .unp_i   (unp_b),
    .bg_i    (bg_q),
    .valid_o (res_valid),
    .rgb_o   (rgb_res)
  );

  assign rgb_o.valid     = res_valid;
  assign rgb_o.out_red   = rgb_res[IdxR];
  assign rgb_o.out_green = rgb_res[IdxG];
  assign rgb_o.out_blue  = rgb_res[IdxB];

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rgb_o.valid && !rgb_o.ready |-> !pix_i.ready)
    else $error("input accepted while output stalled");

  a_blend_alpha_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_b.valid && ctl_b.mode == MODE_BLEND |-> ctl_b.alpha != 8'h00 && ctl_b.alpha != 8'hff)
    else $error("blend path with transparent or opaque alpha");

  a_unpremul_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_b.valid && ctl_b.mode == MODE_BLEND |-> unp_b[IdxR] >= chan_b[IdxR])
    else $error("un-premultiplied red below premultiplied value");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(ctl_b) && $stable(unp_b))
    else $error("pipeline stage moved during stall");

endmodule
